@@ rtl/core/first_fit_free_list_allocator_unit_defines.svh @@
// assertion macros for the first-fit free list allocator
// used by ffal_ctrl under rtl/core, no other dependency
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FFAL_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define FFAL_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define FFAL_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define FFAL_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/core/ffal_pkg.sv @@
// shared types and constants of the first-fit free list allocator
// no dependencies
package ffal_pkg;

   localparam int HEAP_UNITS     = 65536;
   localparam int ADDR_W         = 16;
   localparam int UNIT_BYTES     = 16;
   localparam int UNIT_SHIFT     = 4;
   localparam int SIZE_W         = 17;
   localparam int BYTES_W        = 21;
   localparam int NEED_W         = 18;
   localparam int GROW_W         = 16;
   localparam int BREAK_W        = 17;
   localparam int STEP_W         = 18;
   localparam int WALK_LIMIT     = 2 * HEAP_UNITS + 8;
   localparam int GROW_MIN_RESET = 4096;
   localparam int ENTRY_W        = ADDR_W + SIZE_W;

   localparam logic CMD_ALLOC  = 1'b0;
   localparam logic CMD_FREE   = 1'b1;
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_OOM = 1'b1;

   typedef struct packed {
      logic [ADDR_W-1:0] link;
      logic [SIZE_W-1:0] size;
   } entry_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      entry_type         wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic              status;
   } result_type;

endpackage

@@ rtl/core/ffal_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module ffal_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_data_ff <= mem_ff[raddr];
   end

   assign rdata = rd_data_ff;

endmodule

@@ rtl/core/ffal_ctrl.sv @@
// sequencer: allocate walk, heap growth and address-ordered insert with merge
// depends on ffal_pkg and the assertion macro header
`include "first_fit_free_list_allocator_unit_defines.svh"
module ffal_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_command,
   input  logic [ffal_pkg::BYTES_W-1:0]   req_request_bytes,
   input  logic [ffal_pkg::ADDR_W-1:0]    req_block_address,
   input  logic [ffal_pkg::GROW_W-1:0]    grow_min_units,
   output ffal_pkg::mem_req_type          mem_req,
   input  ffal_pkg::entry_type            mem_rdata,
   input  logic                           out_free,
   output ffal_pkg::result_type           done
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_A_ROOT, ST_A_ROOTD, ST_A_CHK, ST_A_SPLIT, ST_G_HP, ST_F_BP,
      ST_INS_START, ST_INS_WALK, ST_INS_NX, ST_INS_P, ST_G_RESUME, ST_RESP
   } state_type;

   localparam int AW = ffal_pkg::ADDR_W;
   localparam int SW = ffal_pkg::SIZE_W;

   state_type                      state_ff, state_in;
   logic                           started_ff, started_in;
   logic [AW-1:0]                  rover_ff, rover_in;
   logic [ffal_pkg::BREAK_W-1:0]   brk_ff, brk_in;
   logic [AW-1:0]                  units_ff, units_in;
   logic [AW-1:0]                  p_ff, p_in;
   logic [AW-1:0]                  prevp_ff, prevp_in;
   logic [SW-1:0]                  prev_size_ff, prev_size_in;
   logic [ffal_pkg::STEP_W-1:0]    a_steps_ff, a_steps_in;
   logic [ffal_pkg::STEP_W-1:0]    i_steps_ff, i_steps_in;
   logic [AW-1:0]                  bp_ff, bp_in;
   logic [SW-1:0]                  bp_size_ff, bp_size_in;
   logic [AW-1:0]                  nx_ff, nx_in;
   logic [SW-1:0]                  ip_size_ff, ip_size_in;
   logic [AW-1:0]                  bpl_ff, bpl_in;
   logic [SW-1:0]                  bps_ff, bps_in;
   logic [AW-1:0]                  q_ff, q_in;
   logic                           grow_ff, grow_in;
   logic [AW-1:0]                  res_addr_ff, res_addr_in;
   logic                           res_status_ff, res_status_in;

   logic [ffal_pkg::BYTES_W:0]     bytes_up;
   logic [ffal_pkg::NEED_W-1:0]    need;
   logic [SW-1:0]                  split_size;
   logic [AW-1:0]                  nu;
   logic [ffal_pkg::BREAK_W:0]     brk_sum;
   logic [ffal_pkg::STEP_W-1:0]    a_steps_inc, i_steps_inc;
   logic                           ins_hit;
   logic [SW-1:0]                  base_size;

   always_comb begin
      bytes_up    = {1'b0, req_request_bytes} + (ffal_pkg::BYTES_W+1)'(ffal_pkg::UNIT_BYTES - 1);
      need        = ffal_pkg::NEED_W'(bytes_up >> ffal_pkg::UNIT_SHIFT) + ffal_pkg::NEED_W'(1);
      split_size  = mem_rdata.size - SW'(units_ff);
      nu          = (units_ff < grow_min_units) ? grow_min_units : units_ff;
      brk_sum     = {1'b0, brk_ff} + (ffal_pkg::BREAK_W+1)'(nu);
      a_steps_inc = a_steps_ff + ffal_pkg::STEP_W'(1);
      i_steps_inc = i_steps_ff + ffal_pkg::STEP_W'(1);
      ins_hit     = ((bp_ff > p_ff) && (bp_ff < mem_rdata.link)) ||
                    ((p_ff >= mem_rdata.link) && ((bp_ff > p_ff) || (bp_ff < mem_rdata.link)));
      base_size   = (p_ff == bp_ff) ? bps_ff : ip_size_ff;
   end

   always_comb begin
      state_in      = state_ff;
      started_in    = started_ff;
      rover_in      = rover_ff;
      brk_in        = brk_ff;
      units_in      = units_ff;
      p_in          = p_ff;
      prevp_in      = prevp_ff;
      prev_size_in  = prev_size_ff;
      a_steps_in    = a_steps_ff;
      i_steps_in    = i_steps_ff;
      bp_in         = bp_ff;
      bp_size_in    = bp_size_ff;
      nx_in         = nx_ff;
      ip_size_in    = ip_size_ff;
      bpl_in        = bpl_ff;
      bps_in        = bps_ff;
      q_in          = q_ff;
      grow_in       = grow_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      mem_req       = '0;
      req_ready     = 1'b0;
      done          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_command == ffal_pkg::CMD_ALLOC) begin
                  if (need > ffal_pkg::NEED_W'(ffal_pkg::HEAP_UNITS - 1)) begin
                     res_addr_in   = '0;
                     res_status_in = ffal_pkg::STATUS_OOM;
                     state_in      = ST_RESP;
                  end else begin
                     units_in = need[AW-1:0];
                     if (!started_ff) begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = '0;
                        mem_req.wdata = '0;
                        rover_in      = '0;
                        started_in    = 1'b1;
                     end
                     state_in = ST_A_ROOT;
                  end
               end else if (!started_ff) begin
                  res_addr_in   = '0;
                  res_status_in = ffal_pkg::STATUS_OK;
                  state_in      = ST_RESP;
               end else begin
                  bp_in         = req_block_address - AW'(1);
                  mem_req.raddr = req_block_address - AW'(1);
                  grow_in       = 1'b0;
                  state_in      = ST_F_BP;
               end
            end
         end
         ST_A_ROOT: begin
            mem_req.raddr = rover_ff;
            prevp_in      = rover_ff;
            a_steps_in    = '0;
            state_in      = ST_A_ROOTD;
         end
         ST_A_ROOTD: begin
            prev_size_in  = mem_rdata.size;
            p_in          = mem_rdata.link;
            mem_req.raddr = mem_rdata.link;
            state_in      = ST_A_CHK;
         end
         ST_A_CHK: begin
            if (mem_rdata.size >= SW'(units_ff)) begin
               rover_in      = prevp_ff;
               res_status_in = ffal_pkg::STATUS_OK;
               mem_req.we    = 1'b1;
               if (mem_rdata.size == SW'(units_ff)) begin
                  mem_req.waddr = prevp_ff;
                  mem_req.wdata = '{link: mem_rdata.link, size: prev_size_ff};
                  res_addr_in   = p_ff + AW'(1);
                  state_in      = ST_RESP;
               end else begin
                  mem_req.waddr = p_ff;
                  mem_req.wdata = '{link: mem_rdata.link, size: split_size};
                  q_in          = p_ff + split_size[AW-1:0];
                  mem_req.raddr = p_ff + split_size[AW-1:0];
                  state_in      = ST_A_SPLIT;
               end
            end else if (p_ff == rover_ff) begin
               if (brk_sum > (ffal_pkg::BREAK_W+1)'(ffal_pkg::HEAP_UNITS)) begin
                  res_addr_in   = '0;
                  res_status_in = ffal_pkg::STATUS_OOM;
                  state_in      = ST_RESP;
               end else begin
                  bp_in         = brk_ff[AW-1:0];
                  bp_size_in    = SW'(nu);
                  brk_in        = brk_sum[ffal_pkg::BREAK_W-1:0];
                  mem_req.raddr = brk_ff[AW-1:0];
                  grow_in       = 1'b1;
                  state_in      = ST_G_HP;
               end
            end else if (a_steps_inc > ffal_pkg::STEP_W'(ffal_pkg::WALK_LIMIT)) begin
               res_addr_in   = '0;
               res_status_in = ffal_pkg::STATUS_OOM;
               state_in      = ST_RESP;
            end else begin
               a_steps_in    = a_steps_inc;
               prevp_in      = p_ff;
               prev_size_in  = mem_rdata.size;
               p_in          = mem_rdata.link;
               mem_req.raddr = mem_rdata.link;
            end
         end
         ST_A_SPLIT: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = q_ff;
            mem_req.wdata = '{link: mem_rdata.link, size: SW'(units_ff)};
            res_addr_in   = q_ff + AW'(1);
            state_in      = ST_RESP;
         end
         ST_G_HP: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = bp_ff;
            mem_req.wdata = '{link: mem_rdata.link, size: bp_size_ff};
            state_in      = ST_INS_START;
         end
         ST_F_BP: begin
            bp_size_in = mem_rdata.size;
            state_in   = ST_INS_START;
         end
         ST_INS_START: begin
            p_in          = rover_ff;
            i_steps_in    = '0;
            mem_req.raddr = rover_ff;
            state_in      = ST_INS_WALK;
         end
         ST_INS_WALK: begin
            if (ins_hit) begin
               nx_in         = mem_rdata.link;
               ip_size_in    = mem_rdata.size;
               mem_req.raddr = mem_rdata.link;
               state_in      = ST_INS_NX;
            end else if (i_steps_inc > ffal_pkg::STEP_W'(ffal_pkg::WALK_LIMIT)) begin
               res_addr_in   = '0;
               res_status_in = grow_ff ? ffal_pkg::STATUS_OOM : ffal_pkg::STATUS_OK;
               state_in      = ST_RESP;
            end else begin
               i_steps_in    = i_steps_inc;
               p_in          = mem_rdata.link;
               mem_req.raddr = mem_rdata.link;
            end
         end
         ST_INS_NX: begin
            if (({1'b0, bp_ff} + (AW+1)'(bp_size_ff)) == (AW+1)'(nx_ff)) begin
               bpl_in = mem_rdata.link;
               bps_in = bp_size_ff + mem_rdata.size;
            end else begin
               bpl_in = nx_ff;
               bps_in = bp_size_ff;
            end
            mem_req.we    = 1'b1;
            mem_req.waddr = bp_ff;
            mem_req.wdata = '{link: bpl_in, size: bps_in};
            state_in      = ST_INS_P;
         end
         ST_INS_P: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = p_ff;
            if (((SW+1)'(p_ff) + (SW+1)'(base_size)) == (SW+1)'(bp_ff)) begin
               mem_req.wdata = '{link: bpl_ff, size: base_size + bps_ff};
            end else begin
               mem_req.wdata = '{link: bp_ff, size: base_size};
            end
            rover_in = p_ff;
            if (grow_ff) begin
               state_in = ST_G_RESUME;
            end else begin
               res_addr_in   = '0;
               res_status_in = ffal_pkg::STATUS_OK;
               state_in      = ST_RESP;
            end
         end
         ST_G_RESUME: begin
            if (a_steps_inc > ffal_pkg::STEP_W'(ffal_pkg::WALK_LIMIT)) begin
               res_addr_in   = '0;
               res_status_in = ffal_pkg::STATUS_OOM;
               state_in      = ST_RESP;
            end else begin
               a_steps_in    = a_steps_inc;
               prevp_in      = rover_ff;
               mem_req.raddr = rover_ff;
               state_in      = ST_A_ROOTD;
            end
         end
         ST_RESP: begin
            done.valid  = 1'b1;
            done.addr   = res_addr_ff;
            done.status = res_status_ff;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         started_ff <= 1'b0;
         rover_ff   <= '0;
         brk_ff     <= ffal_pkg::BREAK_W'(1);
      end else begin
         state_ff   <= state_in;
         started_ff <= started_in;
         rover_ff   <= rover_in;
         brk_ff     <= brk_in;
      end
      units_ff      <= units_in;
      p_ff          <= p_in;
      prevp_ff      <= prevp_in;
      prev_size_ff  <= prev_size_in;
      a_steps_ff    <= a_steps_in;
      i_steps_ff    <= i_steps_in;
      bp_ff         <= bp_in;
      bp_size_ff    <= bp_size_in;
      nx_ff         <= nx_in;
      ip_size_ff    <= ip_size_in;
      bpl_ff        <= bpl_in;
      bps_ff        <= bps_in;
      q_ff          <= q_in;
      grow_ff       <= grow_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
   end

   `FFAL_ASSERT_ALWAYS(a_brk_range, clock, reset, (brk_ff <= ffal_pkg::BREAK_W'(ffal_pkg::HEAP_UNITS)) && (brk_ff != '0), "heap break out of range")
   `FFAL_ASSERT_IMPLY(a_oom_addr, clock, reset, done.valid && (done.status == ffal_pkg::STATUS_OOM), done.addr == '0, "out of memory with nonzero address")
   `FFAL_ASSERT_IMPLY(a_busy_no_req, clock, reset, done.valid, !req_ready, "request taken while result pending")
   `FFAL_ASSERT_IMPLY(a_walk_started, clock, reset, (state_ff == ST_A_CHK) || (state_ff == ST_INS_WALK), started_ff, "list walk before sentinel setup")

endmodule

@@ rtl/core/first_fit_free_list_allocator_unit.sv @@
// top level of the first-fit free list allocator: csr, heap ram, sequencer, response register
// depends on ffal_pkg, ffal_ram and ffal_ctrl
//
//   channel | direction | ports
//   req     | in        | req_valid req_ready req_command req_request_bytes req_block_address
//   rsp     | out       | rsp_valid rsp_ready rsp_payload_address rsp_status
//   csr     | in        | csr_valid csr_ready csr_wdata (grow_min_units)
//
// one request at a time; an allocate walks the free list from the rover until a block fits,
// splitting it when larger, and grows the heap when the walk comes back round, inserting the
// new block in address order; a free inserts alike; results wait in the response register
// the single-port read of the heap ram (one list node per cycle) sets the walk length
// synchronous reset clears control state only; the heap ram needs no clearing pass
// a result waiting in the response register holds the next result in the sequencer until taken
module first_fit_free_list_allocator_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_command,
   input  logic [ffal_pkg::BYTES_W-1:0]  req_request_bytes,
   input  logic [ffal_pkg::ADDR_W-1:0]   req_block_address,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ffal_pkg::ADDR_W-1:0]   rsp_payload_address,
   output logic                          rsp_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ffal_pkg::GROW_W-1:0]   csr_wdata
);

   logic [ffal_pkg::GROW_W-1:0] grow_min_ff;
   logic                        rsp_valid_ff;
   logic [ffal_pkg::ADDR_W-1:0] rsp_addr_ff;
   logic                        rsp_status_ff;
   logic                        out_free;
   ffal_pkg::mem_req_type       mem_req;
   ffal_pkg::entry_type         mem_rdata;
   logic [ffal_pkg::ENTRY_W-1:0] rdata_raw;
   ffal_pkg::result_type        done;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign mem_rdata = ffal_pkg::entry_type'(rdata_raw);

   ffal_ram #(
      .WIDTH (ffal_pkg::ENTRY_W),
      .DEPTH (ffal_pkg::HEAP_UNITS)
   ) u_heap (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .raddr (mem_req.raddr),
      .rdata (rdata_raw)
   );

   ffal_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_request_bytes (req_request_bytes),
      .req_block_address (req_block_address),
      .grow_min_units    (grow_min_ff),
      .mem_req           (mem_req),
      .mem_rdata         (mem_rdata),
      .out_free          (out_free),
      .done              (done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         grow_min_ff  <= ffal_pkg::GROW_W'(ffal_pkg::GROW_MIN_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            grow_min_ff <= csr_wdata;
         end
         if (done.valid && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (done.valid && out_free) begin
         rsp_addr_ff   <= done.addr;
         rsp_status_ff <= done.status;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_payload_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;

endmodule
